[rtl/core/sccp_pkg.sv]
// Shared types and constants for the selective color correction pipeline.
// Pixel word structs, register indexes, fixed-point constants, square root step.
// No dependencies.
package sccp_pkg;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pix_out_t;

  typedef enum logic [2:0] {
    CFG_SELECTED_COLOR  = 3'd0,
    CFG_TARGET_COLOR    = 3'd1,
    CFG_FALLOFF_SETTING = 3'd2,
    CFG_SOURCE_PERCENT  = 3'd3,
    CFG_SATURATION_STEP = 3'd4,
    CFG_BRIGHTNESS_STEP = 3'd5
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // channel lanes inside a packed [2:0][7:0] pixel
  localparam int unsigned CH_RED = 2;

  // logistic table generation, Q30
  localparam longint unsigned Q30_ONE   = 64'd1073741824;
  localparam longint unsigned LN2_Q30   = 64'd744261118;
  localparam int unsigned     EXP_TERMS = 12;

  // falloff k100 = setting * 45 + 500
  localparam int unsigned K100_MUL = 45;
  localparam int unsigned K100_OFS = 500;
  localparam int unsigned K100_MAX = 127 * K100_MUL + K100_OFS;
  localparam int unsigned K100_W   = 13;

  // floor(n/100) by reciprocal multiply
  localparam int unsigned SAT_RECIP   = 21474837; // ceil(2^31/100), n = step*65536
  localparam int unsigned SAT_SHIFT   = 15;       // 31 - 16
  localparam int unsigned BLEND_RECIP = 41944;    // ceil(2^22/100)
  localparam int unsigned BLEND_SHIFT = 22;

  localparam int unsigned SAT_ONE = 65536;

  // digit-by-digit square root state
  typedef struct packed {
    logic [18:0] rem;
    logic [16:0] root;
  } sq_t;

  function automatic sq_t sq_step(sq_t s, logic [1:0] pair);
    logic [20:0] r;
    logic [20:0] trial;
    sq_t         o;
    r     = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (r >= trial) begin
      o.rem  = 19'(r - trial);
      o.root = {s.root[15:0], 1'b1};
    end else begin
      o.rem  = r[18:0];
      o.root = {s.root[15:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[rtl/core/selective_color_correct_pixel.sv]
// Selective color correction top level: fifteen-stage pixel pipeline.
// Uses sccp_pkg for pixel words, register indexes and constants.
// Holds the logistic weight ROM and the reciprocal tables.

// One pixel enters per cycle and passes every stage when the output side
// does not stall; a stall freezes only the stages that are full, so bubbles
// close up and the input keeps taking words while a result waits. The square
// root of the color distance takes three stages, the falloff divide is a
// reciprocal multiply, the weight comes from a registered ROM of
// WEIGHT_TABLE_DEPTH entries, and the saturation divides use a 256-entry
// reciprocal table. Configuration writes are taken every cycle (ready is
// always high) and must happen while no pixel is in flight.
module selective_color_correct_pixel #(
  parameter int unsigned WEIGHT_TABLE_DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             stall_o,
  input  sccp_pkg::pix_in_t                data_i,
  output logic                             valid_o,
  input  logic                             stall_i,
  output sccp_pkg::pix_out_t               data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sccp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sccp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned NST    = 15;
  localparam int unsigned IDX_W  = $clog2(WEIGHT_TABLE_DEPTH);
  localparam int unsigned C_MUL  = 100 * WEIGHT_TABLE_DEPTH;
  localparam int unsigned C_W    = $clog2(C_MUL + 1);
  localparam int unsigned D8_W   = 17;
  localparam int unsigned NP_W   = D8_W + C_W;
  localparam int unsigned N_W    = $clog2(sccp_pkg::K100_MAX * WEIGHT_TABLE_DEPTH);
  localparam int unsigned KS     = N_W + sccp_pkg::K100_W;
  localparam int unsigned RK_W   = KS - 8;
  localparam int unsigned QK_W   = N_W + RK_W;

  // ---------------------------------------------------------------------------
  // elaboration-time table generation
  function automatic logic [63:0] div_u64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], a[k]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_neg_q30(logic [63:0] y);
    logic [63:0] n;
    logic [63:0] g;
    logic [63:0] acc;
    logic [63:0] term;
    n    = y / sccp_pkg::LN2_Q30;
    g    = sccp_pkg::LN2_Q30 - (y - n * sccp_pkg::LN2_Q30);
    acc  = sccp_pkg::Q30_ONE;
    term = sccp_pkg::Q30_ONE;
    for (int unsigned j = 1; j <= sccp_pkg::EXP_TERMS; j++) begin
      term = div_u64((term * g) >> 30, 64'(j));
      acc  = acc + term;
    end
    if (n + 64'd1 >= 64'd63) begin
      return '0;
    end
    return acc >> (n + 64'd1);
  endfunction

  function automatic logic [15:0] w_entry(int unsigned i);
    longint      xq;
    logic [63:0] mag;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] w;
    xq  = longint'((64'd20 * 64'(i) * sccp_pkg::Q30_ONE) / WEIGHT_TABLE_DEPTH)
        - longint'(64'd5 << 29);
    mag = (xq < 0) ? 64'(-xq) : 64'(xq);
    e   = exp_neg_q30(mag);
    den = sccp_pkg::Q30_ONE + e;
    num = (xq >= 0) ? (e << 16) : (sccp_pkg::Q30_ONE << 16);
    w   = div_u64(num + (den >> 1), den);
    return (w > 64'd65535) ? 16'hffff : w[15:0];
  endfunction

  logic [15:0]     wrom   [WEIGHT_TABLE_DEPTH];
  logic [RK_W-1:0] rk_tab [128];
  logic [32:0]     r8_tab [256];

  for (genvar g = 0; g < WEIGHT_TABLE_DEPTH; g++) begin : g_wrom
    localparam logic [15:0] W = w_entry(g);
    assign wrom[g] = W;
  end

  for (genvar g = 0; g < 128; g++) begin : g_rk
    localparam longint unsigned K = g * sccp_pkg::K100_MUL + sccp_pkg::K100_OFS;
    localparam logic [RK_W-1:0] RK = RK_W'(((64'd1 << KS) + K - 64'd1) / K);
    assign rk_tab[g] = RK;
  end

  // ceil(2^32/x); x = 1 needs the 33rd bit
  for (genvar g = 0; g < 256; g++) begin : g_r8
    localparam longint unsigned X = (g == 0) ? 1 : g;
    localparam logic [32:0] R = (g == 0) ? 33'd0 : 33'(((64'd1 << 32) + X - 64'd1) / X);
    assign r8_tab[g] = R;
  end

  // ---------------------------------------------------------------------------
  // configuration registers
  logic [23:0]        sel_q, tgt_q;
  logic [6:0]         fs_q, pct_q;
  logic [7:0]         sat_q, bri_q;
  logic signed [17:0] sst_q, sst_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
      tgt_q <= '0;
      fs_q  <= 7'd1;
      pct_q <= '0;
      sat_q <= '0;
      bri_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sccp_pkg::cfg_idx_e'(cfg_index_i))
        sccp_pkg::CFG_SELECTED_COLOR:  sel_q <= cfg_data_i;
        sccp_pkg::CFG_TARGET_COLOR:    tgt_q <= cfg_data_i;
        sccp_pkg::CFG_FALLOFF_SETTING: fs_q  <= cfg_data_i[6:0];
        sccp_pkg::CFG_SOURCE_PERCENT:  pct_q <= cfg_data_i[6:0];
        sccp_pkg::CFG_SATURATION_STEP: sat_q <= cfg_data_i[7:0];
        sccp_pkg::CFG_BRIGHTNESS_STEP: bri_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // saturation step in signed Q1.16, truncated toward zero
  always_comb begin
    logic [7:0]  mag;
    logic [32:0] qm_full;
    logic [16:0] qm;
    mag     = sat_q[7] ? 8'(-sat_q) : sat_q;
    qm_full = 33'(mag) * 33'(sccp_pkg::SAT_RECIP);
    qm      = qm_full[sccp_pkg::SAT_SHIFT +: 17];
    sst_d   = sat_q[7] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sst_q <= '0;
    end else begin
      sst_q <= sst_d;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || !stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign stall_o = !en[0];
  assign valid_o = v_q[NST-1];

  logic [2:0][7:0] sel_c, tgt_c;
  assign sel_c = sel_q;
  assign tgt_c = tgt_q;

  // ---------------------------------------------------------------------------
  // stage 0: squared distance
  logic [2:0][7:0] src0_d, src0_q;
  logic [17:0]     sum0_d, sum0_q;
  logic            zero0_q;

  always_comb begin
    logic [7:0] df;
    src0_d = {data_i.in_red, data_i.in_green, data_i.in_blue};
    sum0_d = '0;
    for (int c = 0; c < 3; c++) begin
      df     = (src0_d[c] > sel_c[c]) ? src0_d[c] - sel_c[c] : sel_c[c] - src0_d[c];
      sum0_d = sum0_d + 18'(16'(df) * 16'(df));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      src0_q  <= src0_d;
      sum0_q  <= sum0_d;
      zero0_q <= (sum0_d == '0);
    end
  end

  // stages 1..3: d8 = isqrt(sum << 16), six, six and five root bits
  logic [2:0][7:0] src1_q, src2_q, src3_q;
  logic [17:0]     sum1_q, sum2_q;
  sccp_pkg::sq_t   sq1_d, sq1_q, sq2_d, sq2_q, sq3_d;
  logic            zero1_q, zero2_q, zero3_q;
  logic [D8_W-1:0] d8_3_q;

  always_comb begin
    logic [33:0] x;
    x     = {sum0_q, 16'b0};
    sq1_d = '0;
    for (int j = 16; j >= 11; j--) sq1_d = sccp_pkg::sq_step(sq1_d, x[2*j +: 2]);
  end

  always_comb begin
    logic [33:0] x;
    x     = {sum1_q, 16'b0};
    sq2_d = sq1_q;
    for (int j = 10; j >= 5; j--) sq2_d = sccp_pkg::sq_step(sq2_d, x[2*j +: 2]);
  end

  always_comb begin
    logic [33:0] x;
    x     = {sum2_q, 16'b0};
    sq3_d = sq2_q;
    for (int j = 4; j >= 0; j--) sq3_d = sccp_pkg::sq_step(sq3_d, x[2*j +: 2]);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      src1_q <= src0_q; sum1_q <= sum0_q; sq1_q <= sq1_d; zero1_q <= zero0_q;
    end
    if (en[2]) begin
      src2_q <= src1_q; sum2_q <= sum1_q; sq2_q <= sq2_d; zero2_q <= zero1_q;
    end
    if (en[3]) begin
      src3_q <= src2_q; d8_3_q <= sq3_d.root; zero3_q <= zero2_q;
    end
  end

  // stage 4: scale distance, range check against k
  logic [2:0][7:0] src4_q;
  logic [N_W-1:0]  n4_d, n4_q;
  logic            rng4_d, rng4_q, zero4_q;

  always_comb begin
    logic [NP_W-1:0]                 np;
    logic [sccp_pkg::K100_W-1:0]     k100;
    np     = NP_W'(d8_3_q) * NP_W'(C_MUL);
    n4_d   = N_W'(np >> 11);
    k100   = sccp_pkg::K100_W'(fs_q) * sccp_pkg::K100_W'(sccp_pkg::K100_MUL)
           + sccp_pkg::K100_W'(sccp_pkg::K100_OFS);
    rng4_d = (24'(d8_3_q) * 24'd100) < {k100, 11'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      src4_q <= src3_q; n4_q <= n4_d; rng4_q <= rng4_d; zero4_q <= zero3_q;
    end
  end

  // stage 5: table index by reciprocal of k
  logic [2:0][7:0]  src5_q;
  logic [IDX_W-1:0] idx5_d, idx5_q;
  logic             rng5_q, zero5_q;

  always_comb begin
    logic [QK_W-1:0] q;
    q      = QK_W'(n4_q) * QK_W'(rk_tab[fs_q]);
    idx5_d = rng4_q ? q[KS +: IDX_W] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      src5_q <= src4_q; idx5_q <= idx5_d; rng5_q <= rng4_q; zero5_q <= zero4_q;
    end
  end

  // stage 6: weight ROM, registered read
  logic [2:0][7:0] src6_q;
  logic [15:0]     w6_q;
  logic            zero6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      src6_q  <= src5_q;
      w6_q    <= rng5_q ? wrom[idx5_q] : '0;
      zero6_q <= zero5_q;
    end
  end

  // stage 7: move toward target by w
  logic [2:0][7:0] src7_q, c7_d, c7_q;

  always_comb begin
    logic [25:0] mix;
    for (int c = 0; c < 3; c++) begin
      mix = 26'(25'(src6_q[c]) * (25'h10000 - 25'(w6_q))) + 26'(24'(tgt_c[c]) * 24'(w6_q));
      c7_d[c] = zero6_q ? tgt_c[c] : mix[23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      src7_q <= src6_q; c7_q <= c7_d;
    end
  end

  // stage 8: max, min, saturation S = dl*65536/mx
  logic [2:0][7:0] src8_q, c8_q;
  logic [7:0]      mx8_d, mx8_q, dl8_d, dl8_q;
  logic [16:0]     s8_d, s8_q;

  always_comb begin
    logic [7:0]  mn;
    logic [39:0] sp;
    mx8_d = c7_q[0];
    mn    = c7_q[0];
    for (int c = 1; c < 3; c++) begin
      if (c7_q[c] > mx8_d) mx8_d = c7_q[c];
      if (c7_q[c] < mn)    mn    = c7_q[c];
    end
    dl8_d = mx8_d - mn;
    sp    = 40'(dl8_d) * 40'(r8_tab[mx8_d]);
    s8_d  = sp[32:16];
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      src8_q <= src7_q; c8_q <= c7_q; mx8_q <= mx8_d; dl8_q <= dl8_d; s8_q <= s8_d;
    end
  end

  // stage 9: step and clamp, mx*S'
  logic [2:0][7:0] src9_q, c9_q;
  logic [7:0]      mx9_q, dl9_q;
  logic [24:0]     mp9_d, mp9_q;

  always_comb begin
    logic signed [18:0] sn;
    logic [16:0]        s2;
    sn = $signed({2'b00, s8_q}) + 19'(sst_q);
    if (sn < 0) begin
      s2 = '0;
    end else if (sn > $signed(19'(sccp_pkg::SAT_ONE))) begin
      s2 = 17'(sccp_pkg::SAT_ONE);
    end else begin
      s2 = sn[16:0];
    end
    mp9_d = 25'(mx8_q) * 25'(s2);
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      src9_q <= src8_q; c9_q <= c8_q; mx9_q <= mx8_q; dl9_q <= dl8_q; mp9_q <= mp9_d;
    end
  end

  // stage 10: per-channel numerators, grey drop
  logic [2:0][7:0]  src10_q;
  logic [7:0]       mx10_q, dl10_q, gd10_d, gd10_q;
  logic [2:0][32:0] num10_d, num10_q;

  always_comb begin
    logic [25:0] gs;
    for (int c = 0; c < 3; c++) begin
      num10_d[c] = 33'(mp9_q) * 33'(mx9_q - c9_q[c]);
    end
    gs     = 26'(mp9_q) + 26'd65535;
    gd10_d = gs[23:16];
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      src10_q <= src9_q; mx10_q <= mx9_q; dl10_q <= dl9_q;
      num10_q <= num10_d; gd10_q <= gd10_d;
    end
  end

  // stage 11: drop = ceil(ceil(num/65536)/dl) through reciprocal of dl
  logic [2:0][7:0]  src11_q;
  logic [7:0]       mx11_q, dl11_q, gd11_q;
  logic [2:0][16:0] drop11_d, drop11_q;

  always_comb begin
    logic [33:0] ts;
    logic [16:0] a;
    logic [48:0] q;
    for (int c = 0; c < 3; c++) begin
      ts          = 34'(num10_q[c]) + 34'd65535;
      a           = ts[32:16] + 17'(dl10_q) - 17'd1;
      q           = 49'(a) * 49'(r8_tab[dl10_q]);
      drop11_d[c] = q[48:32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      src11_q <= src10_q; mx11_q <= mx10_q; dl11_q <= dl10_q;
      gd11_q <= gd10_q; drop11_q <= drop11_d;
    end
  end

  // stage 12: new channel values, brightness
  logic [2:0][7:0] src12_q, b12_d, b12_q;

  always_comb begin
    logic [7:0] cv;
    logic [8:0] bs;
    for (int c = 0; c < 3; c++) begin
      if (dl11_q == '0) begin
        cv = (c == sccp_pkg::CH_RED) ? mx11_q : mx11_q - gd11_q;
      end else if (drop11_q[c] > 17'(mx11_q)) begin
        cv = '0;
      end else begin
        cv = mx11_q - drop11_q[c][7:0];
      end
      bs       = 9'(cv) + 9'(bri_q);
      b12_d[c] = bs[8] ? 8'hff : bs[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[12]) begin
      src12_q <= src11_q; b12_q <= b12_d;
    end
  end

  // stage 13: blend numerator
  logic [2:0][14:0] x13_d, x13_q;

  always_comb begin
    logic [6:0] p;
    p = (pct_q > 7'd100) ? 7'd100 : pct_q;
    for (int c = 0; c < 3; c++) begin
      x13_d[c] = 15'(p) * 15'(src12_q[c]) + 15'(7'd100 - p) * 15'(b12_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[13]) x13_q <= x13_d;
  end

  // stage 14: divide by 100, output word
  logic [2:0][7:0]    o14;
  sccp_pkg::pix_out_t out14_q;

  always_comb begin
    logic [30:0] pr;
    for (int c = 0; c < 3; c++) begin
      pr     = 31'(x13_q[c]) * 31'(sccp_pkg::BLEND_RECIP);
      o14[c] = pr[sccp_pkg::BLEND_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[14]) begin
      out14_q <= '{out_red: o14[2], out_green: o14[1], out_blue: o14[0]};
    end
  end

  assign data_o = out14_q;

  // ---------------------------------------------------------------------------
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> v_q[0])
    else $error("input stalled with an empty first stage");

  a_far_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[6] && v_q[5] && !rng5_q) |=> (w6_q == '0))
    else $error("far pixel got a nonzero weight");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[8] |-> (s8_q <= 17'(sccp_pkg::SAT_ONE)))
    else $error("saturation above one");

  a_zero_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[7] && v_q[6] && zero6_q) |=> (c7_q == tgt_c))
    else $error("zero distance pixel not replaced by target");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the selective color correction pixel pipeline.
// Predicts each corrected pixel in fixed point and checks the output stream.
// Depends on sccp_pkg and selective_color_correct_pixel.
module tb_top;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned IDLE_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic stall_o;
  sccp_pkg::pix_in_t in_word = '0;
  logic valid_o;
  logic out_stall = 1'b0;
  sccp_pkg::pix_out_t data_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [sccp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sccp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #2 clk_i = ~clk_i;

  selective_color_correct_pixel #(.WEIGHT_TABLE_DEPTH(DEPTH)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .valid_i(in_valid), .stall_o(stall_o), .data_i(in_word),
    .valid_o(valid_o), .stall_i(out_stall), .data_o(data_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // shadow registers
  logic [23:0] sel_color = '0;
  logic [23:0] tgt_color = '0;
  logic [6:0]  falloff = 7'd1;
  logic [6:0]  src_pct = '0;
  logic [7:0]  sat_step = '0;
  logic [7:0]  bright = '0;

  longint unsigned weight_rom [DEPTH];

  sccp_pkg::pix_in_t  pixel_q [$];
  sccp_pkg::pix_out_t corrected_q [$];
  int unsigned errors = 0;
  int unsigned out_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned idle_cycles = 0;
  bit long_hold_done = 0;
  int unsigned hold_left = 0;

  function automatic longint unsigned exp_neg(longint unsigned y);
    longint unsigned n, g, sum, term;
    n = y / sccp_pkg::LN2_Q30;
    g = sccp_pkg::LN2_Q30 - (y - n * sccp_pkg::LN2_Q30);
    sum = sccp_pkg::Q30_ONE;
    term = sccp_pkg::Q30_ONE;
    for (int j = 1; j <= sccp_pkg::EXP_TERMS; j++) begin
      term = ((term * g) >> 30) / longint'(j);
      sum += term;
    end
    if (n + 1 >= 63) return 0;
    return sum >> (n + 1);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      longint xq;
      longint unsigned mag, e, den, num, w;
      xq = longint'((64'd20 * i * sccp_pkg::Q30_ONE) / DEPTH) - longint'(64'd5 << 29);
      mag = xq < 0 ? longint'(-xq) : xq;
      e = exp_neg(mag);
      den = sccp_pkg::Q30_ONE + e;
      num = xq >= 0 ? (e << 16) : (sccp_pkg::Q30_ONE << 16);
      w = (num + den / 2) / den;
      weight_rom[i] = w > 65535 ? 65535 : w;
    end
  end

  function automatic sccp_pkg::pix_out_t predict_corrected(sccp_pkg::pix_in_t px);
    longint unsigned src[3], tgt[3], c[3];
    longint unsigned sum, w, mx, mn, dl, p, d8, k100, idx, b;
    longint ss, snew;
    sccp_pkg::pix_out_t r;
    src[0] = 64'(px.in_red); src[1] = 64'(px.in_green); src[2] = 64'(px.in_blue);
    sum = 0;
    w = 0;
    for (int i = 0; i < 3; i++) begin
      longint unsigned s, diff;
      s = 64'((sel_color >> (16 - 8 * i)) & 24'hFF);
      tgt[i] = 64'((tgt_color >> (16 - 8 * i)) & 24'hFF);
      diff = src[i] > s ? src[i] - s : s - src[i];
      sum += diff * diff;
    end
    if (sum == 0) begin
      for (int i = 0; i < 3; i++) c[i] = tgt[i];
    end else begin
      d8 = int_sqrt(sum << 16);
      k100 = longint'(falloff) * 45 + 500;
      idx = (d8 * 100 * DEPTH) / (2048 * k100);
      if (idx < DEPTH) w = weight_rom[idx];
      for (int i = 0; i < 3; i++) c[i] = (src[i] * (65536 - w) + tgt[i] * w) >> 16;
    end
    mx = c[0]; mn = c[0];
    for (int i = 1; i < 3; i++) begin
      if (c[i] > mx) mx = c[i];
      if (c[i] < mn) mn = c[i];
    end
    dl = mx - mn;
    ss = longint'($signed(sat_step));
    snew = (mx == 0 ? 0 : longint'((dl * 65536) / mx)) + (ss * 65536) / 100;
    if (snew < 0) snew = 0;
    if (snew > 65536) snew = 65536;
    if (mx != 0) begin
      if (dl == 0) begin
        longint unsigned drop;
        drop = (mx * longint'(snew) + 65535) >> 16;
        c[0] = mx; c[1] = mx - drop; c[2] = mx - drop;
      end else begin
        for (int i = 0; i < 3; i++) begin
          longint unsigned num, drop;
          num = mx * longint'(snew) * (mx - c[i]);
          drop = (num + dl * 65536 - 1) / (dl * 65536);
          c[i] = drop > mx ? 0 : mx - drop;
        end
      end
    end
    p = src_pct > 100 ? 100 : 64'(src_pct);
    for (int i = 0; i < 3; i++) begin
      b = c[i] + bright;
      if (b > 255) b = 255;
      c[i] = ((p * src[i] + (100 - p) * b) / 100) & 64'hFF;
    end
    r.out_red = 8'(c[0]); r.out_green = 8'(c[1]); r.out_blue = 8'(c[2]);
    return r;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !stall_o) corrected_q.push_back(predict_corrected(in_word));
      if (!in_valid || !stall_o) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word <= pixel_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (valid_o && !out_stall) begin
        if (corrected_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, data_o);
          errors++;
        end else begin
          sccp_pkg::pix_out_t want;
          want = corrected_q.pop_front();
          if (data_o.out_red !== want.out_red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.out_red, data_o.out_red);
            errors++;
          end
          if (data_o.out_green !== want.out_green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.out_green,
                     data_o.out_green);
            errors++;
          end
          if (data_o.out_blue !== want.out_blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.out_blue,
                     data_o.out_blue);
            errors++;
          end
        end
        out_count++;
      end
      // one long hold-off so the pipe fills and backs up
      if (!long_hold_done && out_count >= 300) begin
        long_hold_done = 1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid && !stall_o) || (valid_o && !out_stall) ||
        (pixel_q.size() == 0 && !in_valid && corrected_q.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [sccp_pkg::CFG_IDX_W-1:0] idx,
                           logic [sccp_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      sccp_pkg::CFG_SELECTED_COLOR:  sel_color = val;
      sccp_pkg::CFG_TARGET_COLOR:    tgt_color = val;
      sccp_pkg::CFG_FALLOFF_SETTING: falloff = val[6:0];
      sccp_pkg::CFG_SOURCE_PERCENT:  src_pct = val[6:0];
      sccp_pkg::CFG_SATURATION_STEP: sat_step = val[7:0];
      sccp_pkg::CFG_BRIGHTNESS_STEP: bright = val[7:0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [23:0] sc, logic [23:0] tc, logic [6:0] fo, logic [6:0] pc,
                       logic [7:0] st, logic [7:0] br);
    write_reg(sccp_pkg::CFG_SELECTED_COLOR, sc);
    write_reg(sccp_pkg::CFG_TARGET_COLOR, tc);
    write_reg(sccp_pkg::CFG_FALLOFF_SETTING, 24'(fo));
    write_reg(sccp_pkg::CFG_SOURCE_PERCENT, 24'(pc));
    write_reg(sccp_pkg::CFG_SATURATION_STEP, 24'(st));
    write_reg(sccp_pkg::CFG_BRIGHTNESS_STEP, 24'(br));
    // unmapped indexes must be ignored
    write_reg(3'd6, 24'($urandom));
    write_reg(3'd7, 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pixel_q.size() == 0 && !in_valid && corrected_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [7:0] near_ch(logic [7:0] base, int unsigned span);
    int v;
    v = int'(base) + int'($urandom_range(2 * span)) - int'(span);
    return v < 0 ? 8'd0 : (v > 255 ? 8'd255 : 8'(v));
  endfunction

  // mostly pixels near the picked color so the weight is nonzero
  task automatic queue_random(int unsigned n);
    sccp_pkg::pix_in_t px;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1, 2: px = 24'($urandom);
        3: px = {near_ch(sel_color[23:16], 3), near_ch(sel_color[15:8], 3),
                 near_ch(sel_color[7:0], 3)};
        4: begin
          px.in_red = 8'($urandom); px.in_green = px.in_red; px.in_blue = px.in_red;
        end
        default: px = {near_ch(sel_color[23:16], 60), near_ch(sel_color[15:8], 60),
                       near_ch(sel_color[7:0], 60)};
      endcase
      pixel_q.push_back(px);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset defaults, then at the extremes
    pixel_q.push_back('0);
    pixel_q.push_back(24'hFFFFFF);
    pixel_q.push_back(24'h808080);
    pixel_q.push_back(24'h010000);
    drain();
    setup(24'h40A0C0, 24'hFF0080, 7'd1, 7'd0, 8'h9C, 8'd0);
    send_idle_pct = 7;
    recv_idle_pct = 69;
    pixel_q.push_back(24'h40A0C0);
    pixel_q.push_back(24'h41A0C0);
    pixel_q.push_back(24'h40A1BF);
    pixel_q.push_back(24'h44A4C4);
    pixel_q.push_back(24'h000000);
    pixel_q.push_back(24'hFFFFFF);
    pixel_q.push_back(24'h555555);
    pixel_q.push_back(24'hFF00FF);
    pixel_q.push_back(24'h00FF00);
    drain();
    setup(24'hFFFFFF, 24'h000000, 7'd100, 7'd100, 8'd100, 8'd255);
    pixel_q.push_back(24'hFFFFFF);
    pixel_q.push_back(24'hFEFEFE);
    pixel_q.push_back(24'h000000);
    pixel_q.push_back(24'h7F00FF);
    drain();
    setup(24'h000000, 24'hFFFFFF, 7'd127, 7'd127, 8'h7F, 8'd200);
    pixel_q.push_back(24'h000000);
    pixel_q.push_back(24'h010101);
    pixel_q.push_back(24'h123456);
    drain();
    setup(24'h123456, 24'hABCDEF, 7'd0, 7'd50, 8'h80, 8'd1);
    pixel_q.push_back(24'h123456);
    pixel_q.push_back(24'h133557);
    pixel_q.push_back(24'hEDCBA9);
    drain();

    // random part; each round re-programs all registers
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 7; recv_idle_pct = 69;
      end else if (ph < 4) begin
        send_idle_pct = 69; recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      setup(24'($urandom), 24'($urandom), (ph == 5) ? 7'd100 : 7'($urandom_range(127)),
            7'($urandom_range(127)), 8'($urandom), (ph == 4) ? 8'd255 : 8'($urandom));
      queue_random(210);
      drain();
    end

    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
